>>> rtl/core/mme_pkg.sv
package mme_pkg;

  // Sizes of the stores and the arithmetic.
  localparam int MAX_DIM     = 8;
  localparam int DATA_WIDTH  = 16;
  localparam int IDX_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int PROD_W      = 2 * DATA_WIDTH;
  localparam int ACC_W       = (PROD_W + IDX_W > 33) ? PROD_W + IDX_W : 33;

  // Field widths on the streams.
  localparam int ROW_W      = 3;
  localparam int COL_W      = 3;
  localparam int ELEM_W     = 16;
  localparam int RES_W      = 32;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - RES_W - ROW_W - COL_W;

  // Configuration port.
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS = 2'd2;

  // Matrix select codes.
  localparam logic SEL_LEFT  = 1'b0;
  localparam logic SEL_RIGHT = 1'b1;

  // Load queue between the front and the back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Active matrix sizes after clamping.
  typedef struct packed {
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] inner;
    logic [DIM_W-1:0] cols;
  } dims_t;

  // One classified load item.
  typedef struct packed {
    logic                  store;
    logic                  sel;
    logic [ADDR_W-1:0]     addr;
    logic [DATA_WIDTH-1:0] value;
    logic                  done;
  } load_t;

endpackage

>>> rtl/core/mme_ram.sv
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/mme_front.sv
module mme_front import mme_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [IN_DATA_W-1:0] s_tdata,
  input  logic                 s_tlast,
  input  logic                 s_tuser,
  input  logic                 q_full,
  output logic                 q_push,
  output load_t                q_entry,
  output dims_t                dims
);

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'((MAX_DIM < 8) ? MAX_DIM : 8);

  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ELEM_W-1:0] val;
  logic [DIM_W-1:0]  lim_row;
  logic [DIM_W-1:0]  lim_col;

  // A size of zero means one; anything above the store size means the store size.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      return DIM_W'(MAX_DIM);
    end else begin
      return DIM_W'(v);
    end
  endfunction

  // Size registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      dims.rows  <= DIM_RESET;
      dims.inner <= DIM_RESET;
      dims.cols  <= DIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS:    dims.rows  <= clamp_dim(cfg_data);
        CFG_INNER:   dims.inner <= clamp_dim(cfg_data);
        CFG_COLUMNS: dims.cols  <= clamp_dim(cfg_data);
        default:     ;
      endcase
    end
  end

  // Unpack the item and check it against the active sizes.
  always_comb begin
    row = s_tdata[ROW_W-1:0];
    col = s_tdata[ROW_W+COL_W-1:ROW_W];
    val = s_tdata[ROW_W+COL_W+ELEM_W-1:ROW_W+COL_W];
    if (s_tuser == SEL_LEFT) begin
      lim_row = dims.rows;
      lim_col = dims.inner;
    end else begin
      lim_row = dims.inner;
      lim_col = dims.cols;
    end
    q_entry.store = (int'(row) < int'(lim_row)) && (int'(col) < int'(lim_col));
    q_entry.sel   = s_tuser;
    q_entry.addr  = ADDR_W'(int'(row) * MAX_DIM + int'(col));
    q_entry.value = DATA_WIDTH'(val);
    q_entry.done  = s_tlast;
  end

  // Items flow straight into the queue while it has room.
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

endmodule

>>> rtl/core/mme_queue.sv
module mme_queue import mme_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  load_t push_entry,
  output logic  full,
  input  logic  pop,
  output logic  pop_valid,
  output load_t pop_entry
);

  load_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full      = (int'(count) == QUEUE_DEPTH);
  assign pop_valid = (count != '0);
  assign pop_entry = mem[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("queue popped while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + QCNT_W'(1))
    else $error("queue count did not follow a push");
`endif

endmodule

>>> rtl/core/mme_back.sv
module mme_back import mme_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  dims_t                 dims,
  input  logic                  q_valid,
  input  load_t                 q_entry,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAC  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  logic [1:0]               state;
  logic [IDX_W-1:0]         r;
  logic [IDX_W-1:0]         c;
  logic [IDX_W-1:0]         k;
  logic                     issuing;
  logic                     rd_v;
  logic                     rd_last;
  logic                     prod_v;
  logic                     prod_last;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic [RES_W-1:0]         sat_value;

  logic                  issue;
  logic                  issue_last;
  logic                  row_last;
  logic                  col_last;
  logic                  out_last;
  logic                  out_free;
  logic                  out_load;
  logic                  start_run;
  logic                  l_we;
  logic                  r_we;
  logic [ADDR_W-1:0]     l_raddr;
  logic [ADDR_W-1:0]     r_raddr;
  logic [DATA_WIDTH-1:0] l_q;
  logic [DATA_WIDTH-1:0] r_q;

  // Load items are popped only between runs.
  assign q_pop     = (state == ST_IDLE) && q_valid;
  assign start_run = q_pop && q_entry.done;
  assign l_we      = q_pop && q_entry.store && (q_entry.sel == SEL_LEFT);
  assign r_we      = q_pop && q_entry.store && (q_entry.sel == SEL_RIGHT);

  // Operand fetch for one step of the dot product.
  assign issue      = (state == ST_MAC) && issuing;
  assign issue_last = (int'(k) + 1 == int'(dims.inner));
  assign l_raddr    = ADDR_W'(int'(r) * MAX_DIM + int'(k));
  assign r_raddr    = ADDR_W'(int'(k) * MAX_DIM + int'(c));

  // Position and output slot.
  assign row_last = (int'(r) + 1 == int'(dims.rows));
  assign col_last = (int'(c) + 1 == int'(dims.cols));
  assign out_last = row_last && col_last;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_OUT) && out_free;

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_left_store (
    .clk   (clk),
    .we    (l_we),
    .waddr (q_entry.addr),
    .wdata (q_entry.value),
    .raddr (l_raddr),
    .rdata (l_q)
  );

  mme_ram #(.WIDTH(DATA_WIDTH), .DEPTH(STORE_DEPTH)) u_right_store (
    .clk   (clk),
    .we    (r_we),
    .waddr (q_entry.addr),
    .wdata (q_entry.value),
    .raddr (r_raddr),
    .rdata (r_q)
  );

  // Saturate the accumulated sum to a signed 32-bit result.
  always_comb begin
    if (acc > SAT_MAX) begin
      sat_value = RES_W'(SAT_MAX);
    end else if (acc < SAT_MIN) begin
      sat_value = RES_W'(SAT_MIN);
    end else begin
      sat_value = RES_W'(acc);
    end
  end

  // Sequencer over rows, columns and the inner index.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      r        <= '0;
      c        <= '0;
      k        <= '0;
      issuing  <= 1'b0;
      rd_v     <= 1'b0;
      prod_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      rd_v   <= issue;
      prod_v <= rd_v;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (start_run) begin
            state   <= ST_MAC;
            r       <= '0;
            c       <= '0;
            k       <= '0;
            issuing <= 1'b1;
          end
        end
        ST_MAC: begin
          if (issue) begin
            k <= k + IDX_W'(1);
            if (issue_last) begin
              issuing <= 1'b0;
            end
          end
          if (prod_v && prod_last) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            if (out_last) begin
              state <= ST_IDLE;
            end else begin
              state   <= ST_MAC;
              k       <= '0;
              issuing <= 1'b1;
              if (col_last) begin
                c <= '0;
                r <= r + IDX_W'(1);
              end else begin
                c <= c + IDX_W'(1);
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Multiply, accumulate and the output register.
  always_ff @(posedge clk) begin
    rd_last   <= issue_last;
    prod      <= PROD_W'($signed(l_q) * $signed(r_q));
    prod_last <= rd_last;
    if (start_run || (out_load && !out_last)) begin
      acc <= '0;
    end else if (prod_v) begin
      acc <= acc + ACC_W'(prod);
    end
    if (out_load) begin
      m_tdata <= {{OUT_PAD_W{1'b0}}, sat_value, COL_W'(c), ROW_W'(r)};
      m_tlast <= out_last;
    end
  end

`ifndef SYNTHESIS
  a_prod_in_mac: assert property (@(posedge clk) disable iff (rst)
    prod_v |-> state == ST_MAC) else $error("product arrived outside a dot product");
  a_drained_at_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT) |-> (!rd_v && !prod_v && !issuing))
    else $error("pipeline not drained when the result is taken");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && out_last) |=> (state == ST_IDLE && m_tvalid && m_tlast))
    else $error("last result did not end the run");
`endif

endmodule

>>> rtl/core/matrix_multiply_engine.sv
// Channel   Direction  Item                        Handshake
// s_*       in         one matrix element to load  s_tvalid && s_tready
// m_*       out        one result element          m_tvalid && m_tready
// cfg_*     in         one size register write     cfg_we
//
// Loads are taken one per cycle while the four-entry load queue has room.
// Each result element takes one store read per inner step through the single
// multiply-accumulate unit, then the read and product pipeline registers, then
// a load of the output register; a run of R by C results repeats this per element.
// Reset is synchronous; the stores are not cleared and hold nothing defined.
// A stalled output holds the sequencer; loads keep filling the queue meanwhile.
module matrix_multiply_engine import mme_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // elem_row, elem_col, elem_value, pad
  input  logic                  s_tlast,   // load_done
  input  logic                  s_tuser,   // matrix_sel
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // out_row, out_col, product_value, pad
  output logic                  m_tlast    // last_result
);

  dims_t dims;
  load_t push_entry;
  load_t pop_entry;
  logic  q_full;
  logic  q_push;
  logic  q_pop;
  logic  q_valid;

  mme_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (push_entry),
    .dims      (dims)
  );

  mme_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_entry  (pop_entry)
  );

  mme_back u_back (
    .clk      (clk),
    .rst      (rst),
    .dims     (dims),
    .q_valid  (q_valid),
    .q_entry  (pop_entry),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
